[sv/hkrd_pkg.sv]
// Shared types and constants of the HID keyboard report decoder.
package hkrd_pkg;

    localparam int NUM_SLOTS = 6;
    localparam int NUM_CAND  = 2 * NUM_SLOTS;
    localparam int Q_DEPTH   = 2;

    localparam logic [7:0] KEY_CAPS_LOCK   = 8'h39;
    localparam logic [7:0] KEY_NUM_LOCK    = 8'h53;
    localparam logic [7:0] KEY_SCROLL_LOCK = 8'h47;
    localparam logic [2:0] LED_NUM         = 3'h1;
    localparam logic [2:0] LED_CAPS        = 3'h2;
    localparam logic [2:0] LED_SCROLL      = 3'h4;
    localparam logic [7:0] SHIFT_MASK      = 8'h22;

    typedef struct packed {
        logic [7:0]                      mods;
        logic [NUM_SLOTS-1:0][7:0]       codes;
        logic [NUM_SLOTS-1:0]            vld;
    } t_report;

endpackage

[sv/hkrd_if.sv]
// Handshake interfaces for the report input channel and the event output channel.
interface hkrd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] modifier_bits;
    logic [7:0] key_code_a;
    logic [7:0] key_code_b;
    logic [7:0] key_code_c;
    logic [7:0] key_code_d;
    logic [7:0] key_code_e;
    logic [7:0] key_code_f;

    modport source (output valid, modifier_bits, key_code_a, key_code_b, key_code_c,
                    key_code_d, key_code_e, key_code_f, input ready);
    modport sink (input valid, modifier_bits, key_code_a, key_code_b, key_code_c,
                  key_code_d, key_code_e, key_code_f, output ready);
endinterface

interface hkrd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] scan_code;
    logic       went_down;
    logic       went_up;
    logic [7:0] modifier_out;
    logic       caps_active;
    logic [2:0] lock_leds;
    logic       led_write;
    logic       last_of_report;

    modport source (output valid, scan_code, went_down, went_up, modifier_out,
                    caps_active, lock_leds, led_write, last_of_report, input ready);
    modport sink (input valid, scan_code, went_down, went_up, modifier_out,
                  caps_active, lock_leds, led_write, last_of_report, output ready);
endinterface

[sv/hkrd_front.sv]
// Front part: accepts a report and marks each distinct nonzero key code.
module hkrd_front (
    hkrd_in_if.sink          i_in,
    output logic             o_push_valid,
    input  logic             i_push_ready,
    output hkrd_pkg::t_report o_push_data
);
    import hkrd_pkg::*;

    logic [NUM_SLOTS-1:0][7:0] w_codes;
    logic [NUM_SLOTS-1:0]      w_vld;

    assign w_codes = {i_in.key_code_f, i_in.key_code_e, i_in.key_code_d,
                      i_in.key_code_c, i_in.key_code_b, i_in.key_code_a};

    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            w_vld[i] = (w_codes[i] != 8'h00);
            for (int j = 0; j < i; j++) begin
                if (w_codes[j] == w_codes[i]) begin
                    w_vld[i] = 1'b0;
                end
            end
        end
    end

    assign o_push_valid      = i_in.valid;
    assign i_in.ready        = i_push_ready;
    assign o_push_data.mods  = i_in.modifier_bits;
    assign o_push_data.codes = w_codes;
    assign o_push_data.vld   = w_vld;

endmodule

[sv/hkrd_queue.sv]
// Short queue of classified reports between the front and back parts.
module hkrd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    output logic              o_push_ready,
    input  hkrd_pkg::t_report i_push_data,
    output logic              o_pop_valid,
    input  logic              i_pop_ready,
    output hkrd_pkg::t_report o_pop_data
);
    import hkrd_pkg::*;

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(Q_DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(Q_DEPTH);

    t_report         r_mem [Q_DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            w_push;
    logic            w_pop;

    assign o_push_ready = (r_count != CNT_FULL);
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!w_push && w_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

[sv/hkrd_back.sv]
// Back part: compares a report with the previous one and emits key events in order.
module hkrd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_pop_valid,
    output logic              o_pop_ready,
    input  hkrd_pkg::t_report i_pop_data,
    hkrd_out_if.source        o_out
);
    import hkrd_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                      r_state;
    logic [NUM_SLOTS-1:0][7:0] r_prev_code;
    logic [NUM_SLOTS-1:0]      r_prev_vld;
    logic [2:0]                r_lock;
    logic [NUM_CAND-1:0][7:0]  r_code;
    logic [NUM_CAND-1:0]       r_dn;
    logic [NUM_CAND-1:0]       r_pend;
    logic [7:0]                r_mods;
    logic                      r_caps;
    logic                      r_led_wr;
    logic                      r_empty;

    logic                      r_ov;
    logic [7:0]                r_o_scan;
    logic                      r_o_down;
    logic                      r_o_up;
    logic [7:0]                r_o_mods;
    logic                      r_o_caps;
    logic [2:0]                r_o_leds;
    logic                      r_o_wr;
    logic                      r_o_last;

    logic                      w_load;
    logic                      w_slot;
    logic                      w_emit;
    logic [NUM_CAND-1:0]       n_pend;
    logic [2:0]                n_toggle;
    logic [NUM_CAND-1:0]       w_win;
    logic [7:0]                w_sel_code;
    logic                      w_sel_dn;
    logic                      w_last;

    assign o_pop_ready = (r_state == ST_IDLE);
    assign w_load      = i_pop_valid && o_pop_ready;
    assign w_slot      = !r_ov || o_out.ready;
    assign w_emit      = (r_state == ST_RUN) && w_slot;

    always_comb begin
        n_toggle = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            n_pend[i] = i_pop_data.vld[i];
            n_pend[NUM_SLOTS + i] = r_prev_vld[i];
            for (int j = 0; j < NUM_SLOTS; j++) begin
                if (r_prev_vld[j] && r_prev_code[j] == i_pop_data.codes[i]) begin
                    n_pend[i] = 1'b0;
                end
                if (i_pop_data.vld[j] && i_pop_data.codes[j] == r_prev_code[i]) begin
                    n_pend[NUM_SLOTS + i] = 1'b0;
                end
            end
            if (n_pend[i]) begin
                if (i_pop_data.codes[i] == KEY_CAPS_LOCK) begin
                    n_toggle = n_toggle | LED_CAPS;
                end
                if (i_pop_data.codes[i] == KEY_NUM_LOCK) begin
                    n_toggle = n_toggle | LED_NUM;
                end
                if (i_pop_data.codes[i] == KEY_SCROLL_LOCK) begin
                    n_toggle = n_toggle | LED_SCROLL;
                end
            end
        end
    end

    // Pending codes are distinct, so exactly one pending entry is the smallest.
    always_comb begin
        w_sel_code = '0;
        w_sel_dn   = 1'b0;
        for (int i = 0; i < NUM_CAND; i++) begin
            w_win[i] = r_pend[i];
            for (int j = 0; j < NUM_CAND; j++) begin
                if (j != i && r_pend[j] && r_code[j] < r_code[i]) begin
                    w_win[i] = 1'b0;
                end
            end
        end
        for (int i = 0; i < NUM_CAND; i++) begin
            if (w_win[i]) begin
                w_sel_code = w_sel_code | r_code[i];
                w_sel_dn   = w_sel_dn | r_dn[i];
            end
        end
        w_last = r_empty || ((r_pend & ~w_win) == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_prev_vld <= '0;
            r_lock     <= '0;
            r_pend     <= '0;
            r_ov       <= 1'b0;
        end else begin
            if (w_load) begin
                r_state    <= ST_RUN;
                r_prev_vld <= i_pop_data.vld;
                r_lock     <= r_lock ^ n_toggle;
                r_pend     <= n_pend;
            end else if (w_emit) begin
                r_pend <= r_pend & ~w_win;
                if (w_last) begin
                    r_state <= ST_IDLE;
                end
            end
            if (w_emit) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_prev_code <= i_pop_data.codes;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_code[i]             <= i_pop_data.codes[i];
                r_dn[i]               <= 1'b1;
                r_code[NUM_SLOTS + i] <= r_prev_code[i];
                r_dn[NUM_SLOTS + i]   <= 1'b0;
            end
            r_mods   <= i_pop_data.mods;
            r_caps   <= ((i_pop_data.mods & SHIFT_MASK) != '0) || ((r_lock & LED_CAPS) != '0);
            r_led_wr <= (n_toggle != '0);
            r_empty  <= (n_pend == '0);
        end
        if (w_emit) begin
            r_o_scan <= r_empty ? 8'h00 : w_sel_code;
            r_o_down <= !r_empty && w_sel_dn;
            r_o_up   <= !r_empty && !w_sel_dn;
            r_o_mods <= r_mods;
            r_o_caps <= r_caps;
            r_o_leds <= w_last ? r_lock : 3'h0;
            r_o_wr   <= w_last && r_led_wr;
            r_o_last <= w_last;
        end
    end

    assign o_out.valid          = r_ov;
    assign o_out.scan_code      = r_o_scan;
    assign o_out.went_down      = r_o_down;
    assign o_out.went_up        = r_o_up;
    assign o_out.modifier_out   = r_o_mods;
    assign o_out.caps_active    = r_o_caps;
    assign o_out.lock_leds      = r_o_leds;
    assign o_out.led_write      = r_o_wr;
    assign o_out.last_of_report = r_o_last;

endmodule

[sv/hid_keyboard_report_decoder.sv]
// Top level of the HID boot keyboard report decoder.
//
//   Channel  Direction  Carries
//   i_in     sink       modifier byte and six key codes, one report per item
//   o_out    source     one key event per item, last_of_report on the final one
//
// A report is loaded in the back part, which then gives one event per cycle
// while o_out does not stall, at least one per report, in ascending code order.
// The previous report is kept as its list of distinct codes, cleared by reset.
// A two-entry queue lets the front take reports while events are still
// going out, and the output register holds an event while o_out stalls.
module hid_keyboard_report_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hkrd_in_if.sink    i_in,
    hkrd_out_if.source o_out
);
    import hkrd_pkg::*;

    logic    w_push_valid;
    logic    w_push_ready;
    t_report w_push_data;
    logic    w_pop_valid;
    logic    w_pop_ready;
    t_report w_pop_data;

    hkrd_front u_front (
        .i_in         (i_in),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_data  (w_push_data)
    );

    hkrd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_data  (w_push_data),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_data   (w_pop_data)
    );

    hkrd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (w_pop_valid),
        .o_pop_ready (w_pop_ready),
        .i_pop_data  (w_pop_data),
        .o_out       (o_out)
    );

endmodule
